### sv/tpk_pkg.sv
// Shared types and codes for the top-k rank matching block.
package tpk_pkg;

    localparam int FP_W   = 48;
    localparam int CNT_W  = 32;
    localparam int RANK_W = 5;
    localparam int TOT_W  = 6;
    localparam int LIM_W  = 6;

    localparam logic [LIM_W-1:0] KEEP_LIMIT_RESET = 6'd32;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_ANALYZE = 1'b1;
    localparam logic SET_TRAIN    = 1'b0;
    localparam logic SET_TARGET   = 1'b1;
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WALK,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic             func;
        logic             which_set;
        logic [FP_W-1:0]  entry_fingerprint;
        logic [CNT_W-1:0] entry_frequency;
    } in_item_t;

    typedef struct packed {
        logic              result_kind;
        logic [RANK_W-1:0] match_rank;
        logic [FP_W-1:0]   match_fingerprint;
        logic [TOT_W-1:0]  unique_total;
        logic [TOT_W-1:0]  correct_total;
        logic              last;
    } out_item_t;

    // Broadcast from the store to every cell of its row
    typedef struct packed {
        cell_op_t         op;
        logic [FP_W-1:0]  fp;
        logic [CNT_W-1:0] cnt;
    } cell_ctl_t;

    // Command from the sequencer to one store
    typedef struct packed {
        cell_op_t         op;
        logic             clear;
        logic [FP_W-1:0]  fp;
        logic [CNT_W-1:0] cnt;
    } store_cmd_t;

endpackage

### sv/tpk_req_if.sv
// Input channel carrying load and analyze items.
interface tpk_req_if;
    logic               valid;
    logic               ready;
    tpk_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/tpk_rsp_if.sv
// Output channel carrying match and summary items.
interface tpk_rsp_if;
    logic               valid;
    logic               ready;
    tpk_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/tpk_cell.sv
// One rank slot of a store: compare, insert, shift towards rank 0.
module tpk_cell
(
    input  logic                         clk,
    input  tpk_pkg::cell_ctl_t           ctl,
    input  logic                         below_n,
    input  logic                         at_n,
    input  logic                         prev_lt,
    input  logic [tpk_pkg::FP_W-1:0]     prev_fp,
    input  logic [tpk_pkg::CNT_W-1:0]    prev_cnt,
    input  logic [tpk_pkg::FP_W-1:0]     next_fp,
    input  logic [tpk_pkg::CNT_W-1:0]    next_cnt,
    output logic [tpk_pkg::FP_W-1:0]     fp,
    output logic [tpk_pkg::CNT_W-1:0]    cnt,
    output logic                         lt
);

    logic [tpk_pkg::FP_W-1:0]  fp_reg, fp_next;
    logic [tpk_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    assign lt  = cnt_reg < ctl.cnt;
    assign fp  = fp_reg;
    assign cnt = cnt_reg;

    always_comb
    begin
        fp_next  = fp_reg;
        cnt_next = cnt_reg;
        unique case (ctl.op)
            tpk_pkg::CELL_HOLD:
            begin
            end
            tpk_pkg::CELL_INSERT:
            begin
                // Slot at or after the insert point: take the new entry at the point,
                // otherwise move the upper neighbour down
                if ((below_n && lt) || at_n)
                begin
                    if (!prev_lt)
                    begin
                        fp_next  = ctl.fp;
                        cnt_next = ctl.cnt;
                    end
                    else
                    begin
                        fp_next  = prev_fp;
                        cnt_next = prev_cnt;
                    end
                end
            end
            tpk_pkg::CELL_SHIFT:
            begin
                fp_next  = next_fp;
                cnt_next = next_cnt;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        fp_reg  <= fp_next;
        cnt_reg <= cnt_next;
    end

endmodule

### sv/tpk_store.sv
// Rank-ordered store: a row of cells with its fill count and insert decode.
module tpk_store
#(
    parameter int DEPTH  = 32,
    parameter int FILL_W = 6
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  tpk_pkg::store_cmd_t       cmd,
    input  logic [FILL_W-1:0]         lim,
    output logic [FILL_W-1:0]         fill,
    output logic [tpk_pkg::FP_W-1:0]  head_fp
);

    logic [FILL_W-1:0]         fill_reg, fill_next;
    logic [FILL_W-1:0]         n;
    logic                      not_full;
    logic                      accept;
    logic [DEPTH-1:0]          lt_vec;
    logic [DEPTH-1:0]          in_fill;
    tpk_pkg::cell_ctl_t        ctl;
    logic [tpk_pkg::FP_W-1:0]  fp_a  [DEPTH];
    logic [tpk_pkg::CNT_W-1:0] cnt_a [DEPTH];

    assign not_full = fill_reg < lim;
    // Full store takes the entry only if it beats some kept count
    assign accept   = (lim != '0) && (not_full || ((lt_vec & in_fill) != '0));
    assign n        = not_full ? fill_reg : fill_reg - FILL_W'(1);

    always_comb
    begin
        ctl.fp  = cmd.fp;
        ctl.cnt = cmd.cnt;
        ctl.op  = tpk_pkg::CELL_HOLD;
        unique case (cmd.op)
            tpk_pkg::CELL_INSERT: ctl.op = accept ? tpk_pkg::CELL_INSERT : tpk_pkg::CELL_HOLD;
            tpk_pkg::CELL_SHIFT:  ctl.op = tpk_pkg::CELL_SHIFT;
            default:              ctl.op = tpk_pkg::CELL_HOLD;
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                      prev_lt;
        logic [tpk_pkg::FP_W-1:0]  prev_fp, next_fp;
        logic [tpk_pkg::CNT_W-1:0] prev_cnt, next_cnt;

        assign in_fill[i] = FILL_W'(i) < fill_reg;

        if (i == 0)
        begin : g_first
            assign prev_lt  = 1'b0;
            assign prev_fp  = cmd.fp;
            assign prev_cnt = cmd.cnt;
        end
        else
        begin : g_mid
            assign prev_lt  = lt_vec[i-1];
            assign prev_fp  = fp_a[i-1];
            assign prev_cnt = cnt_a[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_fp  = fp_a[i];
            assign next_cnt = cnt_a[i];
        end
        else
        begin : g_inner
            assign next_fp  = fp_a[i+1];
            assign next_cnt = cnt_a[i+1];
        end

        tpk_cell u_cell
        (
            .clk      (clk),
            .ctl      (ctl),
            .below_n  (FILL_W'(i) < n),
            .at_n     (FILL_W'(i) == n),
            .prev_lt  (prev_lt),
            .prev_fp  (prev_fp),
            .prev_cnt (prev_cnt),
            .next_fp  (next_fp),
            .next_cnt (next_cnt),
            .fp       (fp_a[i]),
            .cnt      (cnt_a[i]),
            .lt       (lt_vec[i])
        );
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.clear)
        begin
            fill_next = '0;
        end
        else if (cmd.op == tpk_pkg::CELL_INSERT && accept)
        begin
            fill_next = n + FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    assign fill    = fill_reg;
    assign head_fp = fp_a[0];

endmodule

### sv/topk_rank_match_core.sv
// Top level: sequencer, configuration register and output register.
// Load: accepted in idle, inserted by the cell rows in the next; the next item waits until then.
// Analyze: accepted in idle; ranks 0 to min(train fill, target fill) - 1 are compared, shifting
// both rows towards rank 0 after each, then the walk is left and the summary sent; a waiting
// result stalls its step. A result sits in the output register while the next item is accepted.
// Reset clears both fills, sets keep_limit to 32; stored entries are left as they are.
module topk_rank_match_core
#(
    parameter int STORE_DEPTH       = 32,
    parameter int FINGERPRINT_BYTES = 6
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tpk_pkg::LIM_W-1:0]   cfg_wdata,
    tpk_req_if.sink                     req,
    tpk_rsp_if.source                   rsp
);

    localparam int FILL_W = $clog2(STORE_DEPTH + 1);
    localparam int FPB_W  = 8 * FINGERPRINT_BYTES;
    localparam logic [63:0] FP_MASK64 = (FPB_W >= 64) ? '1 : ((64'd1 << FPB_W) - 64'd1);
    localparam logic [tpk_pkg::FP_W-1:0] FP_MASK = FP_MASK64[tpk_pkg::FP_W-1:0];

    tpk_pkg::state_t           state_reg, state_next;
    tpk_pkg::in_item_t         item_reg;
    tpk_pkg::out_item_t        out_reg, out_next;
    logic                      out_valid_reg, out_valid_next;
    logic [tpk_pkg::LIM_W-1:0] keep_limit_reg, keep_limit_next;
    logic [FILL_W-1:0]         rank_reg, rank_next;
    logic [FILL_W-1:0]         correct_reg, correct_next;

    tpk_pkg::store_cmd_t       train_cmd, target_cmd;
    logic [FILL_W-1:0]         train_fill, target_fill, span, lim;
    logic [tpk_pkg::FP_W-1:0]  train_head, target_head;
    logic                      out_free, walk_done, match;
    logic                      take, step, emit_match, emit_sum;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign span      = (train_fill < target_fill) ? train_fill : target_fill;
    assign walk_done = rank_reg == span;
    assign match     = train_head == target_head;
    assign lim       = (keep_limit_reg > tpk_pkg::LIM_W'(STORE_DEPTH))
                     ? FILL_W'(STORE_DEPTH) : FILL_W'(keep_limit_reg);

    tpk_store #(.DEPTH(STORE_DEPTH), .FILL_W(FILL_W)) u_train
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (train_cmd),
        .lim     (lim),
        .fill    (train_fill),
        .head_fp (train_head)
    );

    tpk_store #(.DEPTH(STORE_DEPTH), .FILL_W(FILL_W)) u_target
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (target_cmd),
        .lim     (lim),
        .fill    (target_fill),
        .head_fp (target_head)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tpk_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (req.data.func == tpk_pkg::FUNC_ANALYZE)
                               ? tpk_pkg::ST_WALK : tpk_pkg::ST_LOAD;
                end
            end
            tpk_pkg::ST_LOAD: state_next = tpk_pkg::ST_IDLE;
            tpk_pkg::ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = tpk_pkg::ST_SUM;
                end
            end
            tpk_pkg::ST_SUM:
            begin
                if (out_free)
                begin
                    state_next = tpk_pkg::ST_IDLE;
                end
            end
            default: state_next = tpk_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        take       = 1'b0;
        step       = 1'b0;
        emit_match = 1'b0;
        emit_sum   = 1'b0;
        train_cmd.op     = tpk_pkg::CELL_HOLD;
        train_cmd.clear  = 1'b0;
        train_cmd.fp     = item_reg.entry_fingerprint;
        train_cmd.cnt    = item_reg.entry_frequency;
        target_cmd.op    = tpk_pkg::CELL_HOLD;
        target_cmd.clear = 1'b0;
        target_cmd.fp    = item_reg.entry_fingerprint;
        target_cmd.cnt   = item_reg.entry_frequency;
        unique case (state_reg)
            tpk_pkg::ST_IDLE: take = req.valid;
            tpk_pkg::ST_LOAD:
            begin
                if (item_reg.which_set == tpk_pkg::SET_TARGET)
                begin
                    target_cmd.op = tpk_pkg::CELL_INSERT;
                end
                else
                begin
                    train_cmd.op = tpk_pkg::CELL_INSERT;
                end
            end
            tpk_pkg::ST_WALK:
            begin
                // Hold the rows while a match waits for the output register
                if (!walk_done && (!match || out_free))
                begin
                    step          = 1'b1;
                    emit_match    = match;
                    train_cmd.op  = tpk_pkg::CELL_SHIFT;
                    target_cmd.op = tpk_pkg::CELL_SHIFT;
                end
            end
            tpk_pkg::ST_SUM:
            begin
                if (out_free)
                begin
                    emit_sum         = 1'b1;
                    train_cmd.clear  = 1'b1;
                    target_cmd.clear = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rank_next       = rank_reg;
        correct_next    = correct_reg;
        keep_limit_next = cfg_we ? cfg_wdata : keep_limit_reg;
        if (take)
        begin
            rank_next    = '0;
            correct_next = '0;
        end
        else if (step)
        begin
            rank_next = rank_reg + FILL_W'(1);
            if (match)
            begin
                correct_next = correct_reg + FILL_W'(1);
            end
        end

        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;
        if (emit_match)
        begin
            out_valid_next             = 1'b1;
            out_next.result_kind       = tpk_pkg::KIND_MATCH;
            out_next.match_rank        = tpk_pkg::RANK_W'(rank_reg);
            out_next.match_fingerprint = train_head;
            out_next.unique_total      = '0;
            out_next.correct_total     = '0;
            out_next.last              = 1'b0;
        end
        else if (emit_sum)
        begin
            out_valid_next             = 1'b1;
            out_next.result_kind       = tpk_pkg::KIND_SUMMARY;
            out_next.match_rank        = '0;
            out_next.match_fingerprint = '0;
            out_next.unique_total      = tpk_pkg::TOT_W'(target_fill);
            out_next.correct_total     = tpk_pkg::TOT_W'(correct_reg);
            out_next.last              = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tpk_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            keep_limit_reg <= tpk_pkg::KEEP_LIMIT_RESET;
            rank_reg       <= '0;
            correct_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            keep_limit_reg <= keep_limit_next;
            rank_reg       <= rank_next;
            correct_reg    <= correct_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (take)
        begin
            item_reg.func              <= req.data.func;
            item_reg.which_set         <= req.data.which_set;
            item_reg.entry_fingerprint <= req.data.entry_fingerprint & FP_MASK;
            item_reg.entry_frequency   <= req.data.entry_frequency;
        end
    end

    assign req.ready = state_reg == tpk_pkg::ST_IDLE;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

endmodule
